### src/gda_pkg.sv
// Shared types, constants and calendar tables for the Gregorian date arithmetic unit.
`default_nettype none

package gda_pkg;

    // Pipeline shape: front end (date check and day number), one middle stage
    // (offset add, difference, range check) and the day-number-to-date split.
    localparam int FRONT_STAGES = 3;
    localparam int SPLIT_STAGES = 7;
    localparam int MID_STAGE    = FRONT_STAGES;
    localparam int STAGES       = FRONT_STAGES + 1 + SPLIT_STAGES;

    // Date status codes, first failing check wins.
    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_DAY_RANGE   = 3'd1,
        STAT_MONTH_RANGE = 3'd2,
        STAT_FEB_DAY     = 3'd3,
        STAT_MONTH_END   = 3'd4
    } status_t;

    typedef struct packed {
        status_t     status;
        logic        leap;
        logic [22:0] jdn;
    } date_info_t;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } cal_date_t;

    localparam logic [3:0]  MONTH_FEB = 4'd2;
    localparam logic [3:0]  MONTH_JUL = 4'd7;
    localparam logic [3:0]  MONTH_DEC = 4'd12;

    localparam logic [12:0] YEAR_BIAS  = 13'd4800;
    localparam logic [14:0] JDN_BIAS   = 15'd32045;
    localparam logic [14:0] SPLIT_BIAS = 15'd32044;
    localparam logic [17:0] DAYS_400Y  = 18'd146097;
    localparam logic [10:0] DAYS_4Y    = 11'd1461;

    // Valid day numbers for years 1 through 9999.
    localparam logic signed [24:0] JDN_FIRST = 25'sd1721426;
    localparam logic signed [24:0] JDN_LAST  = 25'sd5373484;

    // Reciprocal multipliers for division by constants; each is exact over
    // the full width of the dividend it is applied to.
    localparam logic [12:0] DIV100_MUL     = 13'd5243;
    localparam int          DIV100_SHIFT   = 19;
    localparam logic [25:0] DIV146097_MUL  = 26'd60207212;
    localparam int          DIV146097_SHIFT = 43;
    localparam logic [20:0] DIV1461_MUL    = 21'd1469873;
    localparam int          DIV1461_SHIFT  = 31;
    localparam logic [10:0] DIV153_MUL     = 11'd1714;
    localparam int          DIV153_SHIFT   = 18;
    localparam logic [23:0] DIV7_MUL       = 24'd9586981;
    localparam int          DIV7_SHIFT     = 26;

    // Days from March 1 to the start of a month, months counted from March.
    function automatic logic [8:0] days_before(input logic [3:0] mm);
        logic [8:0] days;
        case (mm)
            4'd0:    days = 9'd0;
            4'd1:    days = 9'd31;
            4'd2:    days = 9'd61;
            4'd3:    days = 9'd92;
            4'd4:    days = 9'd122;
            4'd5:    days = 9'd153;
            4'd6:    days = 9'd184;
            4'd7:    days = 9'd214;
            4'd8:    days = 9'd245;
            4'd9:    days = 9'd275;
            4'd10:   days = 9'd306;
            4'd11:   days = 9'd337;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

`default_nettype wire

### src/gda_jdn_calc.sv
// Three-stage date check, leap year flag and Julian day number for one date.
`default_nettype none

module gda_jdn_calc import gda_pkg::*; (
    input  logic                    clk,
    input  logic [FRONT_STAGES-1:0] stage_en,
    input  logic [4:0]              day,
    input  logic [3:0]              month,
    input  logic [13:0]             year,
    output date_info_t              info
);

    // Stage 0: year shift for January and February, month table, year / 100.
    logic        low_month;
    logic [3:0]  mm_idx;
    logic [14:0] yy;
    logic [26:0] y_prod;

    logic [4:0]  s0_day_reg;
    logic [3:0]  s0_month_reg;
    logic [13:0] s0_year_reg;
    logic [7:0]  s0_q100_reg;
    logic [14:0] s0_yy_reg;
    logic [8:0]  s0_before_reg;

    assign low_month = (month <= MONTH_FEB);
    assign mm_idx    = low_month ? (month + 4'd9) : (month - 4'd3);
    assign yy        = 15'(year) + 15'(YEAR_BIAS) - {14'd0, low_month};
    assign y_prod    = 27'(year) * 27'(DIV100_MUL);

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            s0_day_reg    <= day;
            s0_month_reg  <= month;
            s0_year_reg   <= year;
            s0_q100_reg   <= y_prod[DIV100_SHIFT +: 8];
            s0_yy_reg     <= yy;
            s0_before_reg <= days_before(mm_idx);
        end
    end

    // Stage 1: leap flag, status, shifted year / 100.
    logic [14:0] h100;
    logic [13:0] r100;
    logic        leap;
    logic        short_month;
    status_t     status_next;
    logic [27:0] yy_prod;

    logic        s1_leap_reg;
    status_t     s1_status_reg;
    logic [9:0]  s1_dt_reg;
    logic [14:0] s1_yy_reg;
    logic [7:0]  s1_c100_reg;

    assign h100 = 15'(s0_q100_reg) * 15'd100;
    assign r100 = s0_year_reg - h100[13:0];
    assign leap = (s0_year_reg[1:0] == 2'b00)
                  && ((r100 != 14'd0) || (s0_q100_reg[1:0] == 2'b00));
    assign short_month = (s0_month_reg <= MONTH_JUL) ? !s0_month_reg[0] : s0_month_reg[0];
    assign yy_prod = 28'(s0_yy_reg) * 28'(DIV100_MUL);

    always_comb
    begin
        if (s0_day_reg == 5'd0)
            status_next = STAT_DAY_RANGE;
        else if ((s0_month_reg == 4'd0) || (s0_month_reg > MONTH_DEC))
            status_next = STAT_MONTH_RANGE;
        else if ((s0_month_reg == MONTH_FEB) && (s0_day_reg > (leap ? 5'd29 : 5'd28)))
            status_next = STAT_FEB_DAY;
        else if ((s0_day_reg == 5'd31) && short_month)
            status_next = STAT_MONTH_END;
        else
            status_next = STAT_OK;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            s1_leap_reg   <= leap;
            s1_status_reg <= status_next;
            s1_dt_reg     <= 10'(s0_day_reg) + 10'(s0_before_reg);
            s1_yy_reg     <= s0_yy_reg;
            s1_c100_reg   <= yy_prod[DIV100_SHIFT +: 8];
        end
    end

    // Stage 2: day number sum.
    logic [23:0] jdn_sum;
    date_info_t  info_reg;

    assign jdn_sum = 24'(s1_dt_reg) + 24'(s1_yy_reg) * 24'd365 + 24'(s1_yy_reg[14:2])
                     - 24'(s1_c100_reg) + 24'(s1_c100_reg[7:2]) - 24'(JDN_BIAS);

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            info_reg.status <= s1_status_reg;
            info_reg.leap   <= s1_leap_reg;
            info_reg.jdn    <= jdn_sum[22:0];
        end
    end

    assign info = info_reg;

endmodule

`default_nettype wire

### src/gda_date_split.sv
// Seven-stage conversion of a Julian day number back to a Gregorian date.
`default_nettype none

module gda_date_split import gda_pkg::*; (
    input  logic                    clk,
    input  logic [SPLIT_STAGES-1:0] stage_en,
    input  logic [22:0]             shift_jdn,
    output cal_date_t               date
);

    logic [22:0] s0_a_reg;
    logic [22:0] s1_a_reg;
    logic [7:0]  s1_b_reg;
    logic [7:0]  s2_b_reg;
    logic [17:0] s2_c_reg;
    logic [7:0]  s3_b_reg;
    logic [17:0] s3_c_reg;
    logic [8:0]  s3_dd_reg;
    logic [7:0]  s4_b_reg;
    logic [8:0]  s4_dd_reg;
    logic [8:0]  s4_e_reg;
    logic [7:0]  s5_b_reg;
    logic [8:0]  s5_dd_reg;
    logic [8:0]  s5_e_reg;
    logic [3:0]  s5_mm_reg;
    cal_date_t   date_reg;

    logic [50:0] b_prod;
    logic [24:0] cyc_days;
    logic [22:0] c_full;
    logic [40:0] dd_prod;
    logic [19:0] quad_days;
    logic [17:0] e_full;
    logic [10:0] m5;
    logic [21:0] mm_prod;
    logic        late;
    logic [8:0]  day_sum;
    logic [15:0] year_sum;

    // Split into centuries, then years within the century, then months.
    assign b_prod    = 51'({s0_a_reg, 2'b11}) * 51'(DIV146097_MUL);
    assign cyc_days  = 25'(s1_b_reg) * 25'(DAYS_400Y);
    assign c_full    = s1_a_reg - cyc_days[24:2];
    assign dd_prod   = 41'({s2_c_reg, 2'b11}) * 41'(DIV1461_MUL);
    assign quad_days = 20'(s3_dd_reg) * 20'(DAYS_4Y);
    assign e_full    = s3_c_reg - quad_days[19:2];
    assign m5        = 11'(s4_e_reg) * 11'd5 + 11'd2;
    assign mm_prod   = 22'(m5) * 22'(DIV153_MUL);

    // Months counted from March: the last two belong to the next year.
    assign late     = (s5_mm_reg >= 4'd10);
    assign day_sum  = s5_e_reg - days_before(s5_mm_reg) + 9'd1;
    assign year_sum = 16'(s5_b_reg) * 16'd100 + 16'(s5_dd_reg) + {15'd0, late}
                      - 16'(YEAR_BIAS);

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            s0_a_reg <= shift_jdn + 23'(SPLIT_BIAS);
        end
        if (stage_en[1])
        begin
            s1_a_reg <= s0_a_reg;
            s1_b_reg <= b_prod[DIV146097_SHIFT +: 8];
        end
        if (stage_en[2])
        begin
            s2_b_reg <= s1_b_reg;
            s2_c_reg <= c_full[17:0];
        end
        if (stage_en[3])
        begin
            s3_b_reg  <= s2_b_reg;
            s3_c_reg  <= s2_c_reg;
            s3_dd_reg <= dd_prod[DIV1461_SHIFT +: 9];
        end
        if (stage_en[4])
        begin
            s4_b_reg  <= s3_b_reg;
            s4_dd_reg <= s3_dd_reg;
            s4_e_reg  <= e_full[8:0];
        end
        if (stage_en[5])
        begin
            s5_b_reg  <= s4_b_reg;
            s5_dd_reg <= s4_dd_reg;
            s5_e_reg  <= s4_e_reg;
            s5_mm_reg <= mm_prod[DIV153_SHIFT +: 4];
        end
        if (stage_en[6])
        begin
            date_reg.day   <= day_sum[4:0];
            date_reg.month <= late ? (s5_mm_reg - 4'd9) : (s5_mm_reg + 4'd3);
            date_reg.year  <= year_sum[13:0];
        end
    end

    assign date = date_reg;

endmodule

`default_nettype wire

### src/gregorian_date_arithmetic_unit.sv
// Top level of the Gregorian date arithmetic unit: handshake, pipeline control and results.
//
//   channel   direction  handshake             payload
//   --------  ---------  --------------------  ---------------------------------------------
//   request   in         src_valid, src_stall  day, month, year, other_day, other_month,
//                                              other_year, offset_days
//   result    out        dst_valid, dst_stall  status, other_status, is_leap, day_number,
//                                              weekday, difference, shifted_day,
//                                              shifted_month, shifted_year, shift_overflow
//
// Every request passes eleven register stages before its result is offered, and one
// request can enter per cycle unless a result stall has reached the input. The depth is
// set by the day-number-to-date split: seven stages for its chain of constant divisions.
// Reset clears only the per-stage valid bits; payload registers are not reset.
// A stall on the result side holds the last stage and ripples back one stage only
// where the stage behind is full, so bubbles close up and nothing is lost or repeated.
`default_nettype none

module gregorian_date_arithmetic_unit import gda_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               src_valid,
    output logic               src_stall,
    input  logic [4:0]         day,
    input  logic [3:0]         month,
    input  logic [13:0]        year,
    input  logic [4:0]         other_day,
    input  logic [3:0]         other_month,
    input  logic [13:0]        other_year,
    input  logic signed [22:0] offset_days,

    output logic               dst_valid,
    input  logic               dst_stall,
    output logic [2:0]         status,
    output logic [2:0]         other_status,
    output logic               is_leap,
    output logic [22:0]        day_number,
    output logic [2:0]         weekday,
    output logic signed [23:0] difference,
    output logic [4:0]         shifted_day,
    output logic [3:0]         shifted_month,
    output logic [13:0]        shifted_year,
    output logic               shift_overflow
);

    // Result fields that ride alongside the date split.
    typedef struct packed {
        status_t     status;
        status_t     other_status;
        logic        leap;
        logic [22:0] jdn;
        logic [2:0]  weekday;
        logic [23:0] diff;
        logic        overflow;
        logic        zero_shift;
    } side_t;

    // Per-stage valid bits and load enables. A stage loads when it is empty or
    // when the stage ahead of it is moving.
    logic [STAGES-1:0] pipe_valid_reg;
    logic [STAGES-1:0] pipe_en;

    always_comb
    begin
        pipe_en[STAGES-1] = !pipe_valid_reg[STAGES-1] || !dst_stall;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            pipe_en[k] = !pipe_valid_reg[k] || pipe_en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_valid_reg <= '0;
        end
        else
        begin
            if (pipe_en[0])
                pipe_valid_reg[0] <= src_valid;
            for (int k = 1; k < STAGES; k++)
            begin
                if (pipe_en[k])
                    pipe_valid_reg[k] <= pipe_valid_reg[k-1];
            end
        end
    end

    assign src_stall = !pipe_en[0];
    assign dst_valid = pipe_valid_reg[STAGES-1];

    // Front end: both dates are checked and numbered in parallel.
    date_info_t first_info;
    date_info_t second_info;

    gda_jdn_calc u_first (
        .clk      (clk),
        .stage_en (pipe_en[FRONT_STAGES-1:0]),
        .day      (day),
        .month    (month),
        .year     (year),
        .info     (first_info)
    );

    gda_jdn_calc u_second (
        .clk      (clk),
        .stage_en (pipe_en[FRONT_STAGES-1:0]),
        .day      (other_day),
        .month    (other_month),
        .year     (other_year),
        .info     (second_info)
    );

    // The offset travels beside the front end.
    logic [22:0] offset_reg [FRONT_STAGES];

    always_ff @(posedge clk)
    begin
        if (pipe_en[0])
            offset_reg[0] <= offset_days;
        for (int k = 1; k < FRONT_STAGES; k++)
        begin
            if (pipe_en[k])
                offset_reg[k] <= offset_reg[k-1];
        end
    end

    // Middle stage: offset add and range check, difference, and the first half of
    // the weekday (quotient by seven). An invalid first date zeroes everything that
    // depends on its day number; an invalid second date zeroes the difference.
    logic                first_ok;
    logic                second_ok;
    logic [22:0]         jdn_masked;
    logic [22:0]         offset_mid;
    logic signed [24:0]  shift_sum;
    logic                out_of_range;
    logic [46:0]         wq_prod;
    logic [23:0]         diff_full;

    status_t             mid_status_reg;
    status_t             mid_other_status_reg;
    logic                mid_leap_reg;
    logic [22:0]         mid_jdn_reg;
    logic [20:0]         mid_wq_reg;
    logic [23:0]         mid_diff_reg;
    logic                mid_overflow_reg;
    logic                mid_zero_reg;
    logic [22:0]         mid_shift_reg;

    assign first_ok   = (first_info.status == STAT_OK);
    assign second_ok  = (second_info.status == STAT_OK);
    assign jdn_masked = first_ok ? first_info.jdn : 23'd0;
    assign offset_mid = offset_reg[FRONT_STAGES-1];
    assign shift_sum  = $signed({2'b00, first_info.jdn})
                        + $signed({{2{offset_mid[22]}}, offset_mid});
    assign out_of_range = (shift_sum < JDN_FIRST) || (shift_sum > JDN_LAST);
    assign wq_prod    = 47'(jdn_masked) * 47'(DIV7_MUL);
    assign diff_full  = {1'b0, first_info.jdn} - {1'b0, second_info.jdn};

    always_ff @(posedge clk)
    begin
        if (pipe_en[MID_STAGE])
        begin
            mid_status_reg       <= first_info.status;
            mid_other_status_reg <= second_info.status;
            mid_leap_reg         <= first_info.leap;
            mid_jdn_reg          <= jdn_masked;
            mid_wq_reg           <= wq_prod[DIV7_SHIFT +: 21];
            mid_diff_reg         <= (first_ok && second_ok) ? diff_full : 24'd0;
            mid_overflow_reg     <= first_ok && out_of_range;
            mid_zero_reg         <= !first_ok || out_of_range;
            mid_shift_reg        <= shift_sum[22:0];
        end
    end

    // Date split of the shifted day number.
    cal_date_t split_date;

    gda_date_split u_split (
        .clk       (clk),
        .stage_en  (pipe_en[STAGES-1:MID_STAGE+1]),
        .shift_jdn (mid_shift_reg),
        .date      (split_date)
    );

    // Side fields follow the split stage by stage; the weekday remainder is
    // finished on entry.
    logic [23:0] seven_q;
    side_t       side_next;
    side_t       side_reg [SPLIT_STAGES];
    side_t       side_out;

    assign seven_q = 24'(mid_wq_reg) * 24'd7;

    always_comb
    begin
        side_next.status       = mid_status_reg;
        side_next.other_status = mid_other_status_reg;
        side_next.leap         = mid_leap_reg;
        side_next.jdn          = mid_jdn_reg;
        side_next.weekday      = 3'(mid_jdn_reg - seven_q[22:0]);
        side_next.diff         = mid_diff_reg;
        side_next.overflow     = mid_overflow_reg;
        side_next.zero_shift   = mid_zero_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en[MID_STAGE+1])
            side_reg[0] <= side_next;
        for (int k = 1; k < SPLIT_STAGES; k++)
        begin
            if (pipe_en[MID_STAGE+1+k])
                side_reg[k] <= side_reg[k-1];
        end
    end

    assign side_out = side_reg[SPLIT_STAGES-1];

    // Result fields.
    assign status         = side_out.status;
    assign other_status   = side_out.other_status;
    assign is_leap        = side_out.leap;
    assign day_number     = side_out.jdn;
    assign weekday        = side_out.weekday;
    assign difference     = $signed(side_out.diff);
    assign shifted_day    = side_out.zero_shift ? 5'd0 : split_date.day;
    assign shifted_month  = side_out.zero_shift ? 4'd0 : split_date.month;
    assign shifted_year   = side_out.zero_shift ? 14'd0 : split_date.year;
    assign shift_overflow = side_out.overflow;

endmodule

`default_nettype wire

### tb/tb_gregorian_date_arithmetic_unit.sv
// Testbench for the Gregorian date arithmetic unit: directed and random date requests checked against a predictor.
`timescale 1ns / 1ps

module tb_gregorian_date_arithmetic_unit;
    import gda_pkg::*;

    // The run is ended by force if it has not finished by the cycle limit.
    localparam int CYCLE_LIMIT = 1000000;
    // Length of the long receiver hold-off used to fill the pipeline.
    localparam int HOLD_OFF_LENGTH = 300;

    // One request as it enters the block.
    typedef struct {
        logic [4:0]         day;
        logic [3:0]         month;
        logic [13:0]        year;
        logic [4:0]         other_day;
        logic [3:0]         other_month;
        logic [13:0]        other_year;
        logic signed [22:0] offset_days;
    } date_request_t;

    // The fields that the block returns for one request.
    typedef struct {
        status_t            status;
        status_t            other_status;
        logic               is_leap;
        logic [22:0]        day_number;
        logic [2:0]         weekday;
        logic signed [23:0] difference;
        logic [4:0]         shifted_day;
        logic [3:0]         shifted_month;
        logic [13:0]        shifted_year;
        logic               shift_overflow;
    } date_result_t;

    logic clk = 1'b0;
    logic rst_n;

    logic               src_valid;
    logic               src_stall;
    logic [4:0]         day;
    logic [3:0]         month;
    logic [13:0]        year;
    logic [4:0]         other_day;
    logic [3:0]         other_month;
    logic [13:0]        other_year;
    logic signed [22:0] offset_days;

    logic               dst_valid;
    logic               dst_stall;
    logic [2:0]         status;
    logic [2:0]         other_status;
    logic               is_leap;
    logic [22:0]        day_number;
    logic [2:0]         weekday;
    logic signed [23:0] difference;
    logic [4:0]         shifted_day;
    logic [3:0]         shifted_month;
    logic [13:0]        shifted_year;
    logic               shift_overflow;

    // Results predicted for accepted requests, oldest first.
    date_result_t pending_results[$];
    int error_count = 0;
    int cycle_count = 0;

    // Idling controls. The sender and the receiver each insert random gaps only
    // while their flag is set. A nonzero hold_off_cycles makes the receiver stall
    // no matter what its flag says, until it has counted down to zero.
    bit sender_idle   = 1'b1;
    bit receiver_idle = 1'b1;
    int hold_off_cycles = 0;

    gregorian_date_arithmetic_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .src_valid      (src_valid),
        .src_stall      (src_stall),
        .day            (day),
        .month          (month),
        .year           (year),
        .other_day      (other_day),
        .other_month    (other_month),
        .other_year     (other_year),
        .offset_days    (offset_days),
        .dst_valid      (dst_valid),
        .dst_stall      (dst_stall),
        .status         (status),
        .other_status   (other_status),
        .is_leap        (is_leap),
        .day_number     (day_number),
        .weekday        (weekday),
        .difference     (difference),
        .shifted_day    (shifted_day),
        .shifted_month  (shifted_month),
        .shifted_year   (shifted_year),
        .shift_overflow (shift_overflow)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------

    // Gregorian rule: every fourth year, except centuries not divisible by 400.
    function automatic logic is_leap_year(input int unsigned y);
        logic leap;
        leap = (y % 4 == 0);
        if (y % 100 == 0)
            leap = 1'b0;
        if (y % 400 == 0)
            leap = 1'b1;
        return leap;
    endfunction

    // The checks run in a fixed order and the first one that fails names the
    // status. The year itself is never checked.
    function automatic status_t date_status(input int unsigned d, input int unsigned m,
                                            input int unsigned y);
        int unsigned month_len;
        if (d < 1 || d > 31)
            return STAT_DAY_RANGE;
        if (m < 1 || m > 12)
            return STAT_MONTH_RANGE;
        if (m == 2 && d > (is_leap_year(y) ? 29 : 28))
            return STAT_FEB_DAY;
        // Long months alternate starting with January, and again from August.
        month_len = (m <= 7) ? 30 + m % 2 : 30 + (m + 1) % 2;
        if (d > month_len)
            return STAT_MONTH_END;
        return STAT_OK;
    endfunction

    // Julian day number of a date whose month is known to be 1 to 12. The year
    // is counted from March so that the leap day falls at the end of the year.
    function automatic longint day_number_of(input longint d, input longint m, input longint y);
        longint a;
        longint yy;
        longint mm;
        a  = (14 - m) / 12;
        yy = y + 4800 - a;
        mm = m + 12 * a - 3;
        return d + (153 * mm + 2) / 5 + 365 * yy + yy / 4 - yy / 100 + yy / 400 - 32045;
    endfunction

    function automatic date_result_t predict_date_result(input date_request_t rq);
        date_result_t r;
        longint first_jdn;
        longint shifted;
        longint wd;
        longint diff;
        longint a;
        longint b;
        longint c;
        longint dd;
        longint e;
        longint mm;
        longint sd;
        longint sm;
        longint sy;

        r.status         = date_status(rq.day, rq.month, rq.year);
        r.other_status   = date_status(rq.other_day, rq.other_month, rq.other_year);
        r.is_leap        = is_leap_year(rq.year);
        r.day_number     = '0;
        r.weekday        = '0;
        r.difference     = '0;
        r.shifted_day    = '0;
        r.shifted_month  = '0;
        r.shifted_year   = '0;
        r.shift_overflow = 1'b0;

        // An invalid first date leaves every computed field at zero.
        if (r.status == STAT_OK)
        begin
            first_jdn    = day_number_of(rq.day, rq.month, rq.year);
            wd           = first_jdn % 7;
            r.day_number = first_jdn[22:0];
            r.weekday    = wd[2:0];
            if (r.other_status == STAT_OK)
            begin
                diff = first_jdn - day_number_of(rq.other_day, rq.other_month, rq.other_year);
                r.difference = diff[23:0];
            end

            shifted = first_jdn + longint'(rq.offset_days);
            if (shifted < JDN_FIRST || shifted > JDN_LAST)
                r.shift_overflow = 1'b1;
            else
            begin
                // Split the day number back into century, year-in-century and
                // day-of-year parts, then map the March-based month back.
                a  = shifted + 32044;
                b  = (4 * a + 3) / 146097;
                c  = a - (146097 * b) / 4;
                dd = (4 * c + 3) / 1461;
                e  = c - (1461 * dd) / 4;
                mm = (5 * e + 2) / 153;
                sd = e - (153 * mm + 2) / 5 + 1;
                sm = mm + 3 - 12 * (mm / 10);
                sy = 100 * b + dd - 4800 + mm / 10;
                r.shifted_day   = sd[4:0];
                r.shifted_month = sm[3:0];
                r.shifted_year  = sy[13:0];
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int idle_length();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic date_request_t make_request(input int d, input int m, input int y,
                                                   input int od, input int om, input int oy,
                                                   input int off);
        date_request_t rq;
        rq.day         = 5'(d);
        rq.month       = 4'(m);
        rq.year        = 14'(y);
        rq.other_day   = 5'(od);
        rq.other_month = 4'(om);
        rq.other_year  = 14'(oy);
        rq.offset_days = 23'(off);
        return rq;
    endfunction

    // A raw date has any day and month the ports allow; otherwise the date is
    // valid, with month ends and leap days showing up often.
    function automatic void pick_date(input bit raw, input logic [13:0] y,
                                      output logic [4:0] d, output logic [3:0] m);
        if (raw)
        begin
            d = 5'($urandom);
            m = 4'($urandom);
        end
        else
        begin
            m = 4'($urandom_range(1, 12));
            d = 5'($urandom_range(1, 31));
            if (date_status(d, m, y) != STAT_OK)
                d = 5'($urandom_range(1, 28));
        end
    endfunction

    // Most requests carry valid dates so that the day number, the difference
    // and the shift are exercised; the rest are malformed dates.
    function automatic date_request_t random_request();
        date_request_t rq;
        int unsigned pick;
        int unsigned span;
        pick = $urandom_range(0, 99);
        rq.year       = 14'($urandom_range(1, 9999));
        rq.other_year = 14'($urandom_range(1, 9999));
        // A share of first dates sits at the ends of the calendar, where small
        // offsets cross into overflow.
        if (pick < 10)
            rq.year = ($urandom_range(0, 1) == 1) ? 14'($urandom_range(9997, 9999))
                                                  : 14'($urandom_range(1, 3));
        pick_date(pick >= 80, rq.year, rq.day, rq.month);
        pick_date($urandom_range(0, 99) >= 85, rq.other_year, rq.other_day, rq.other_month);

        span = $urandom_range(0, 99);
        if (pick < 10 || span < 45)
            rq.offset_days = 23'(int'($urandom_range(0, 4000)) - 2000);
        else if (span < 75)
            rq.offset_days = 23'(int'($urandom_range(0, 3000000)) - 1500000);
        else
            rq.offset_days = 23'($urandom);
        return rq;
    endfunction

    // Offers one request and returns at the edge that accepts it. The valid is
    // lowered only when a gap is taken, so it never drops between back-to-back
    // requests.
    task automatic send_request(input date_request_t rq);
        int gap;
        gap = sender_idle ? idle_length() : 0;
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid   <= 1'b1;
        day         <= rq.day;
        month       <= rq.month;
        year        <= rq.year;
        other_day   <= rq.other_day;
        other_month <= rq.other_month;
        other_year  <= rq.other_year;
        offset_days <= rq.offset_days;
        do
            @(posedge clk);
        while (src_stall);
        pending_results.push_back(predict_date_result(rq));
    endtask

    // Stops offering and waits until every predicted result has come back,
    // then lets the pipeline run empty.
    task automatic wait_for_results();
        src_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (STAGES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Calendar extremes, every status code in both dates, leap rules and the
    // largest offsets in both directions.
    task automatic test_directed_dates();
        send_request(make_request(1, 1, 1, 1, 1, 1, 0));
        send_request(make_request(31, 12, 9999, 1, 1, 1, 0));
        send_request(make_request(1, 1, 1, 31, 12, 9999, -1));
        send_request(make_request(31, 12, 9999, 31, 12, 9999, 1));
        send_request(make_request(15, 6, 5000, 15, 6, 5000, 4194303));
        send_request(make_request(15, 6, 5000, 1, 1, 1, -4194304));
        send_request(make_request(1, 3, 2000, 28, 2, 2000, -1));
        send_request(make_request(29, 2, 2000, 29, 2, 1900, 365));
        send_request(make_request(29, 2, 1900, 1, 1, 2000, 12345));
        send_request(make_request(30, 2, 2024, 29, 2, 2024, 7));
        send_request(make_request(29, 2, 2024, 29, 2, 2023, 366));
        send_request(make_request(31, 4, 2021, 31, 11, 2021, 0));
        send_request(make_request(31, 9, 2021, 31, 7, 2021, 1));
        send_request(make_request(31, 7, 2021, 31, 8, 2021, 31));
        send_request(make_request(0, 0, 2021, 0, 5, 2021, 0));
        send_request(make_request(5, 0, 2021, 5, 13, 2021, 0));
        send_request(make_request(31, 15, 2021, 31, 12, 2021, 0));
        send_request(make_request(31, 12, 8191, 1, 1, 8192, 1));
        send_request(make_request(28, 2, 2100, 1, 3, 2100, 1));
        send_request(make_request(31, 12, 1999, 1, 1, 2000, 1));
        send_request(make_request(31, 1, 4000, 30, 6, 4000, 29));
        send_request(make_request(1, 1, 1, 31, 12, 9999, 4194303));
    endtask

    // The bulk of the run: random requests with both sides idling at random.
    task automatic test_random_traffic();
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        repeat (1300) send_request(random_request());
    endtask

    // A stretch at full rate with no idling on either side.
    task automatic test_streaming();
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        repeat (200) send_request(random_request());
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering, so the pipeline fills and stalls its input.
    task automatic test_result_backpressure();
        sender_idle     = 1'b0;
        receiver_idle   = 1'b0;
        hold_off_cycles = HOLD_OFF_LENGTH;
        repeat (100) send_request(random_request());
        receiver_idle = 1'b1;
    endtask

    // Bursts of requests, each followed by a pause until all results are in.
    task automatic test_sender_pause();
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        repeat (5)
        begin
            repeat (30) send_request(random_request());
            wait_for_results();
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // The receiver stalls in random bursts, or for the full hold-off when one
    // is requested. It assigns dst_stall once per edge.
    initial
    begin : result_receiver
        int stall_left;
        stall_left = 0;
        dst_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                dst_stall <= 1'b1;
                hold_off_cycles--;
            end
            else if (!receiver_idle)
            begin
                stall_left = 0;
                dst_stall <= 1'b0;
            end
            else
            begin
                if (stall_left == 0 && $urandom_range(0, 4) == 0)
                    stall_left = idle_length();
                if (stall_left > 0)
                begin
                    dst_stall <= 1'b1;
                    stall_left--;
                end
                else
                    dst_stall <= 1'b0;
            end
        end
    end

    task automatic compare_field(input string name, input logic signed [63:0] expected_value,
                                 input logic signed [63:0] actual_value);
        if (actual_value !== expected_value)
        begin
            $error("%s: expected %0d, got %0d", name, expected_value, actual_value);
            error_count++;
        end
    endtask

    // Every result accepted at an edge is checked against the oldest prediction.
    always @(posedge clk)
    begin
        date_result_t want;
        if (rst_n && dst_valid && !dst_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result arrived with no request outstanding");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("status", want.status, status);
                compare_field("other_status", want.other_status, other_status);
                compare_field("is_leap", want.is_leap, is_leap);
                compare_field("day_number", want.day_number, day_number);
                compare_field("weekday", want.weekday, weekday);
                compare_field("difference", want.difference, difference);
                compare_field("shifted_day", want.shifted_day, shifted_day);
                compare_field("shifted_month", want.shifted_month, shifted_month);
                compare_field("shifted_year", want.shifted_year, shifted_year);
                compare_field("shift_overflow", want.shift_overflow, shift_overflow);
            end
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_gregorian_date_arithmetic_unit: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin
        // All inputs start at known values while reset is held low.
        rst_n       = 1'b0;
        src_valid   = 1'b0;
        day         = '0;
        month       = '0;
        year        = '0;
        other_day   = '0;
        other_month = '0;
        other_year  = '0;
        offset_days = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_dates();
        test_random_traffic();
        test_streaming();
        test_result_backpressure();
        test_sender_pause();

        // Drain, then give a stray extra result time to show up.
        wait_for_results();
        repeat (2 * STAGES) @(posedge clk);
        if (error_count == 0)
            $display("tb_gregorian_date_arithmetic_unit: PASS");
        else
            $display("tb_gregorian_date_arithmetic_unit: FAIL");
        $finish;
    end

endmodule
